@@ rtl/avs_pkg.sv @@
// Shared types and constants for the audio/video sync frame delay block.
// No dependencies; every other file in rtl/ depends on this package.
package avs_pkg;

    localparam int TICK_W  = 32;
    localparam int TICK_FR = 16;
    localparam int DEF_W   = 20;
    localparam int PTS_W   = 48;
    localparam int CLK_W   = 40;
    localparam int DELAY_W = 21;
    localparam int DIFF_W  = 41;
    localparam int PROD_W  = PTS_W - 1 + TICK_W - TICK_FR;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 1'd1;

    localparam logic [TICK_W-1:0] TICK_RESET    = 32'd65536;
    localparam logic [DEF_W-1:0]  DEFAULT_RESET = 20'd40000;

    localparam logic signed [DIFF_W-1:0] NEAR_US = 41'sd3000;
    localparam logic signed [DIFF_W-1:0] FAR_US  = 41'sd500000;
    localparam logic signed [DIFF_W-1:0] LOST_US = 41'sd10000000;

    // ceil(2^24 / 3): exact floor(x / 3) for any x below 2^22.
    localparam int DIV3_SH = 24;
    localparam logic [22:0] DIV3_M = 23'd5592406;

    typedef struct packed {
        logic             upd;
        logic [CLK_W-1:0] scaled;
        logic [CLK_W-1:0] audio;
    } t_scl;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic                     gt_near;
        logic                     lt_near;
        logic                     ge_far;
        logic                     le_far;
        logic                     lost;
    } t_cls;

endpackage

@@ rtl/avs_if.sv @@
// Valid/ready channel interfaces for frame words and result words.
// Depends on avs_pkg for field widths.
interface avs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                has_pts;
    logic signed [avs_pkg::PTS_W-1:0]    pts;
    logic        [avs_pkg::CLK_W-1:0]    audio_clock_us;

    modport source (output valid, has_pts, pts, audio_clock_us, input ready);
    modport sink   (input valid, has_pts, pts, audio_clock_us, output ready);
endinterface

interface avs_out_if;
    logic                                valid;
    logic                                ready;
    logic        [avs_pkg::DELAY_W-1:0]  delay_us;
    logic signed [avs_pkg::DIFF_W-1:0]   diff_us;

    modport source (output valid, delay_us, diff_us, input ready);
    modport sink   (input valid, delay_us, diff_us, output ready);
endinterface

@@ rtl/avs_scale.sv @@
// Timestamp scaling pipeline: input register, partial products, sum and saturate.
// Depends on avs_pkg.
module avs_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [avs_pkg::TICK_W-1:0]    i_tick,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_has_pts,
    input  logic [avs_pkg::PTS_W-1:0]     i_pts,
    input  logic [avs_pkg::CLK_W-1:0]     i_audio,
    output logic                          o_valid,
    input  logic                          i_ready,
    output avs_pkg::t_scl                 o_data
);
    import avs_pkg::*;

    logic              r_a_valid;
    logic              r_a_pos;
    logic [PTS_W-2:0]  r_a_p;
    logic [CLK_W-1:0]  r_a_audio;
    logic              r_b_valid;
    logic              r_b_pos;
    logic [PROD_W-1:0] r_b_hi;
    logic [PTS_W-2:0]  r_b_lo;
    logic [CLK_W-1:0]  r_b_audio;
    logic              r_c_valid;
    t_scl              r_c_data;

    logic              w_rdy_a;
    logic              w_rdy_b;
    logic              w_rdy_c;
    logic              n_a_pos;
    logic [PROD_W-1:0] n_b_hi;
    logic [PROD_W-1:0] w_lo_full;
    logic [PROD_W-1:0] w_sum;
    t_scl              n_c_data;

    assign w_rdy_c = !r_c_valid || i_ready;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    // Only a present, nonzero, positive timestamp can move the video clock.
    assign n_a_pos = i_has_pts && (i_pts != '0) && !i_pts[PTS_W-1];

    // The Q16.16 factor is split into integer and fraction halves.
    assign n_b_hi    = PROD_W'(r_a_p) * PROD_W'(i_tick[TICK_W-1:TICK_FR]);
    assign w_lo_full = PROD_W'(r_a_p) * PROD_W'(i_tick[TICK_FR-1:0]);

    always_comb begin
        w_sum           = r_b_hi + PROD_W'(r_b_lo);
        n_c_data.upd    = r_b_pos && (w_sum != '0);
        n_c_data.scaled = (|w_sum[PROD_W-1:CLK_W]) ? '1 : w_sum[CLK_W-1:0];
        n_c_data.audio  = r_b_audio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_pos   <= n_a_pos;
            r_a_p     <= i_pts[PTS_W-2:0];
            r_a_audio <= i_audio;
        end
        if (w_rdy_b && r_a_valid) begin
            r_b_pos   <= r_a_pos;
            r_b_hi    <= n_b_hi;
            r_b_lo    <= w_lo_full[PROD_W-1:TICK_FR];
            r_b_audio <= r_a_audio;
        end
        if (w_rdy_c && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule

@@ rtl/avs_clock.sv @@
// Video clock register, audio minus video difference and its threshold flags.
// Depends on avs_pkg.
module avs_clock (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  avs_pkg::t_scl i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output avs_pkg::t_cls o_data
);
    import avs_pkg::*;

    logic [CLK_W-1:0] r_vc;
    logic             r_valid;
    t_cls             r_data;

    logic             w_fire;
    logic [CLK_W-1:0] n_vc;
    t_cls             n_data;

    assign o_ready = !r_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign n_vc    = i_data.upd ? i_data.scaled : r_vc;

    always_comb begin
        n_data.diff    = $signed({1'b0, i_data.audio}) - $signed({1'b0, n_vc});
        n_data.gt_near = n_data.diff > NEAR_US;
        n_data.lt_near = n_data.diff < -NEAR_US;
        n_data.ge_far  = n_data.diff >= FAR_US;
        n_data.le_far  = n_data.diff <= -FAR_US;
        n_data.lost    = (n_data.diff >= LOST_US) || (n_data.diff <= -LOST_US);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_vc <= n_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/avs_delay.sv @@
// Frame delay adaptation with the kept delay register and the result register.
// Depends on avs_pkg.
module avs_delay (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [avs_pkg::DEF_W-1:0]   i_default,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  avs_pkg::t_cls               i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [avs_pkg::DELAY_W-1:0] o_delay,
    output logic [avs_pkg::DIFF_W-1:0]  o_diff
);
    import avs_pkg::*;

    // floor(x / 3) for 22-bit x by a reciprocal multiply.
    function automatic logic [DELAY_W:0] f_div3(input logic [DELAY_W:0] x);
        logic [DELAY_W+24:0] p;
        p = (DELAY_W+25)'(x) * (DELAY_W+25)'(DIV3_M);
        return p[DIV3_SH+DELAY_W:DIV3_SH];
    endfunction

    logic [DELAY_W-1:0] r_frame_delay;
    logic [DELAY_W-1:0] r_def23;
    logic               r_valid;
    logic [DELAY_W-1:0] r_delay;
    logic [DIFF_W-1:0]  r_diff;

    logic               w_fire;
    logic [DELAY_W-1:0] w_def2;
    logic [DELAY_W:0]   w_dn;
    logic [DELAY_W+1:0] w_up3;
    logic [DELAY_W:0]   w_adapt;
    logic [DELAY_W-1:0] w_clamped;
    logic [DELAY_W-1:0] n_delay;
    logic [DELAY_W:0]   w_def23_full;

    assign o_ready = !r_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_def2  = {i_default, 1'b0};
    assign w_def23_full = f_div3({1'b0, w_def2});

    always_comb begin
        w_dn    = f_div3({r_frame_delay, 1'b0});
        w_up3   = {1'b0, r_frame_delay, 1'b0} + {2'b00, r_frame_delay};
        w_adapt = i_data.gt_near ? w_dn : w_up3[DELAY_W+1:1];

        // Pull the adapted delay back into half to twice the default.
        if ({w_adapt, 1'b0} < {2'b00, i_default}) begin
            w_clamped = r_def23;
        end else if (w_adapt > {1'b0, w_def2}) begin
            w_clamped = w_def2;
        end else begin
            w_clamped = w_adapt[DELAY_W-1:0];
        end

        n_delay = (i_data.gt_near || i_data.lt_near) ? w_clamped : r_frame_delay;
        if (i_data.ge_far) begin
            n_delay = '0;
        end else if (i_data.le_far) begin
            n_delay = w_def2;
        end
        if (i_data.lost) begin
            n_delay = DELAY_W'(i_default);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_delay <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_frame_delay <= n_delay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_def23 <= w_def23_full[DELAY_W-1:0];
        if (w_fire) begin
            r_delay <= n_delay;
            r_diff  <= i_data.diff;
        end
    end

    assign o_valid = r_valid;
    assign o_delay = r_delay;
    assign o_diff  = r_diff;

endmodule

@@ rtl/av_sync_frame_delay.sv @@
// Audio/video sync frame delay: top level with configuration registers.
// Depends on avs_pkg, avs_if, avs_scale, avs_clock and avs_delay.
//
// One frame word enters on i_in_ch: has_pts, pts (stream ticks) and the audio
// clock in microseconds. One result word leaves on o_out_ch per frame: the wait
// before showing the frame and the audio minus video clock difference.
// Both channels use valid/ready; a word moves when both are high.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data: index 0 is the
// Q16.16 tick length, index 1 the default delay. The user must write it only
// while no frame is in flight; the block does not enforce this. One frame per
// cycle is sustained while o_out_ch.ready is high. The stages are the input
// register, the timestamp multiply (two 47x16 products), the sum and saturation,
// the video clock and difference, and delay adaptation into the result register.
// Each stage holds its own word, so when the receiver stalls the stages fill
// one after another and i_in_ch.ready drops only once all five are occupied.
// Reset clears the video clock and kept delay, empties the pipeline and loads
// the default configuration (one microsecond per tick, 40 ms delay).
module av_sync_frame_delay (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    avs_in_if.sink                        i_in_ch,
    avs_out_if.source                     o_out_ch,
    input  logic                          i_cfg_we,
    input  logic [avs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [avs_pkg::TICK_W-1:0]    i_cfg_data
);
    import avs_pkg::*;

    logic [TICK_W-1:0] r_tick;
    logic [DEF_W-1:0]  r_default;

    logic w_scl_valid;
    logic w_scl_ready;
    t_scl w_scl_data;
    logic w_cls_valid;
    logic w_cls_ready;
    t_cls w_cls_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= TICK_RESET;
            r_default <= DEFAULT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK:    r_tick    <= i_cfg_data;
                CFG_DEFAULT: r_default <= i_cfg_data[DEF_W-1:0];
                default:     r_tick    <= r_tick;
            endcase
        end
    end

    avs_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (r_tick),
        .i_valid   (i_in_ch.valid),
        .o_ready   (i_in_ch.ready),
        .i_has_pts (i_in_ch.has_pts),
        .i_pts     (i_in_ch.pts),
        .i_audio   (i_in_ch.audio_clock_us),
        .o_valid   (w_scl_valid),
        .i_ready   (w_scl_ready),
        .o_data    (w_scl_data)
    );

    avs_clock u_clock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_scl_valid),
        .o_ready (w_scl_ready),
        .i_data  (w_scl_data),
        .o_valid (w_cls_valid),
        .i_ready (w_cls_ready),
        .o_data  (w_cls_data)
    );

    avs_delay u_delay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_default (r_default),
        .i_valid   (w_cls_valid),
        .o_ready   (w_cls_ready),
        .i_data    (w_cls_data),
        .o_valid   (o_out_ch.valid),
        .i_ready   (o_out_ch.ready),
        .o_delay   (o_out_ch.delay_us),
        .o_diff    (o_out_ch.diff_us)
    );

    // A large positive offset short of lost sync drops the wait to zero.
    a_far_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && (o_out_ch.diff_us >= FAR_US) && (o_out_ch.diff_us < LOST_US))
        |-> (o_out_ch.delay_us == '0))
        else $error("far positive offset did not clear the delay");

    // Lost sync always falls back to the configured default.
    a_lost_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && ((o_out_ch.diff_us >= LOST_US) || (o_out_ch.diff_us <= -LOST_US)))
        |-> (o_out_ch.delay_us == DELAY_W'(r_default)))
        else $error("lost sync did not restore the default delay");

    // The pipeline is empty right after reset, so a frame is taken at once.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> i_in_ch.ready)
        else $error("input not ready after reset");

    // Whenever the result register is free or being emptied, the clock stage can pass a word on.
    a_cls_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.ready || !o_out_ch.valid) |-> w_cls_ready)
        else $error("delay stage blocked while its output is free");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for av_sync_frame_delay: directed and random frame words
// under several register settings, predicted results checked field by field.
// Depends on rtl/avs_pkg.sv, rtl/avs_if.sv and the block's RTL.
module testbench;
    import avs_pkg::*;

    // Keeps its own video clock, kept delay and register copies, and the results
    // that the accepted frame words must produce, oldest first.
    class av_delay_tracker;
        logic [TICK_W-1:0]        tick_q16;
        logic [DEF_W-1:0]         def_us;
        logic [CLK_W-1:0]         video_us;
        logic [DELAY_W-1:0]       delay_us;
        logic [DELAY_W-1:0]       want_delay_q[$];
        logic signed [DIFF_W-1:0] want_diff_q[$];
        int                       errors;
        int                       noted;
        int                       checked;

        function new();
            tick_q16 = TICK_RESET;
            def_us   = DEFAULT_RESET;
            video_us = '0;
            delay_us = '0;
            errors   = 0;
            noted    = 0;
            checked  = 0;
        endfunction

        function void set_config(logic [TICK_W-1:0] tick, logic [DEF_W-1:0] dflt);
            tick_q16 = tick;
            def_us   = dflt;
        endfunction

        // Timestamp in microseconds, or zero when there is none or it is not positive.
        function logic [CLK_W-1:0] ticks_to_us(logic has, logic signed [PTS_W-1:0] pts);
            logic [PTS_W+TICK_W-1:0] prod;
            if (!has || pts <= 0)
                return '0;
            prod = {{TICK_W{1'b0}}, pts} * {{PTS_W{1'b0}}, tick_q16};
            prod = prod >> TICK_FR;
            if (prod[PTS_W+TICK_W-1:CLK_W] != 0)
                return '1;
            return prod[CLK_W-1:0];
        endfunction

        function longint unsigned clamp_to_default(longint unsigned d);
            longint unsigned dflt;
            dflt = def_us;
            if (d * 2 < dflt)
                return (dflt * 2) / 3;
            if (d > dflt * 2)
                return dflt * 2;
            return d;
        endfunction

        function void note_frame(logic has, logic signed [PTS_W-1:0] pts,
                                 logic [CLK_W-1:0] audio);
            logic [CLK_W-1:0]         scaled;
            logic signed [DIFF_W-1:0] diff;
            longint unsigned          d;
            scaled = ticks_to_us(has, pts);
            if (scaled != 0)
                video_us = scaled;
            diff = $signed({1'b0, audio}) - $signed({1'b0, video_us});
            d = delay_us;
            // Inside the near window the kept delay is left alone, clamp included.
            if (diff > NEAR_US)
                d = clamp_to_default((d * 2) / 3);
            else if (diff < -NEAR_US)
                d = clamp_to_default((d * 3) / 2);
            if (diff >= FAR_US)
                d = 0;
            else if (diff <= -FAR_US)
                d = longint'(def_us) * 2;
            if (diff >= LOST_US || diff <= -LOST_US)
                d = def_us;
            delay_us = d[DELAY_W-1:0];
            want_delay_q.push_back(delay_us);
            want_diff_q.push_back(diff);
            noted++;
        endfunction

        function void check_result(logic [DELAY_W-1:0] got_delay,
                                   logic signed [DIFF_W-1:0] got_diff);
            logic [DELAY_W-1:0]       want_delay;
            logic signed [DIFF_W-1:0] want_diff;
            if (want_delay_q.size() == 0) begin
                $display("%0t: unexpected result word, delay %0d diff %0d",
                         $time, got_delay, got_diff);
                errors++;
                return;
            end
            want_delay = want_delay_q.pop_front();
            want_diff  = want_diff_q.pop_front();
            checked++;
            if (got_delay !== want_delay) begin
                $display("%0t: delay_us mismatch, expected %0d, actual %0d",
                         $time, want_delay, got_delay);
                errors++;
            end
            if (got_diff !== want_diff) begin
                $display("%0t: diff_us mismatch, expected %0d, actual %0d",
                         $time, want_diff, got_diff);
                errors++;
            end
        endfunction

        function int pending();
            return want_delay_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_data;

    avs_in_if  in_ch();
    avs_out_if out_ch();

    av_sync_frame_delay uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    av_delay_tracker sb = new();

    bit     tx_gaps;
    bit     rx_stalls;
    int     stall_left;
    longint cur_pts;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!rx_stalls) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 20) begin
            out_ch.ready <= 1'b0;
            stall_left   <= idle_len() - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.delay_us, out_ch.diff_us);
    end

    function automatic logic [CLK_W-1:0] clip_audio(longint a);
        if (a < 0)
            return '0;
        if (a > 64'sh00FF_FFFF_FFFF)
            return '1;
        return a[CLK_W-1:0];
    endfunction

    // Audio minus video offset, spread over the near, far and lost regions
    // and their edges.
    function automatic longint pick_offset();
        longint mag;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return longint'($urandom_range(0, 6000)) - 3000;
        if (r < 65) begin
            mag = $urandom_range(3001, 499999);
        end else if (r < 80) begin
            mag = $urandom_range(500000, 9999999);
        end else if (r < 88) begin
            mag = 10000000 + longint'($urandom) * $urandom_range(1, 200);
        end else begin
            case ($urandom_range(0, 6))
                0: mag = 2999;
                1: mag = 3000;
                2: mag = 3001;
                3: mag = 499999;
                4: mag = 500000;
                5: mag = 9999999;
                default: mag = 10000000;
            endcase
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic send_frame(input logic has, input logic signed [PTS_W-1:0] pts,
                              input logic [CLK_W-1:0] audio);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.has_pts        <= has;
        in_ch.pts            <= pts;
        in_ch.audio_clock_us <= audio;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_frame(has, pts, audio);
    endtask

    // Sends a frame whose audio clock sits at the given offset from the video
    // clock that this frame will leave behind.
    task automatic send_offset(input logic has, input logic signed [PTS_W-1:0] pts,
                               input longint off);
        logic [CLK_W-1:0] vc;
        vc = sb.ticks_to_us(has, pts);
        if (vc == 0)
            vc = sb.video_us;
        send_frame(has, pts, clip_audio(longint'(vc) + off));
    endtask

    task automatic wait_idle();
        int n;
        in_ch.valid <= 1'b0;
        n = 0;
        while (sb.pending() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [TICK_W-1:0] tick, input logic [DEF_W-1:0] dflt);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TICK;
        i_cfg_data <= tick;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEFAULT;
        i_cfg_data <= {{(TICK_W-DEF_W){1'b0}}, dflt};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config(tick, dflt);
        cur_pts = $urandom_range(0, 1000);
    endtask

    task automatic run_frames(input int count);
        logic signed [PTS_W-1:0] tp;
        int                      r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // A steadily advancing stream with the audio clock at a near, far or lost offset.
                cur_pts += $urandom_range(1, 60000);
                if (cur_pts >= (64'sd1 <<< 46))
                    cur_pts = $urandom_range(0, 1000);
                send_offset(1'b1, PTS_W'(cur_pts), pick_offset());
            end else if (r < 75) begin
                send_offset(1'b0, PTS_W'({$urandom, $urandom}), pick_offset());
            end else if (r < 85) begin
                send_frame(1'($urandom_range(0, 1)), PTS_W'({$urandom, $urandom}),
                           CLK_W'({$urandom, $urandom}));
            end else if (r < 92) begin
                tp = $urandom_range(0, 1) ? PTS_W'($urandom_range(0, 3))
                                          : PTS_W'($urandom_range(0, 70000));
                if ($urandom_range(0, 1))
                    tp = -tp;
                send_offset(1'b1, tp, pick_offset());
            end else begin
                // The stream jumps somewhere else entirely.
                cur_pts = longint'($urandom) * $urandom_range(1, 1000);
                send_offset(1'b1, PTS_W'(cur_pts), pick_offset());
            end
            if ($urandom_range(0, 199) == 0)
                wait_idle();
        end
    endtask

    initial begin
        #8_000_000;
        $display("Timeout with %0d results still expected", sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_TICK;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.has_pts        = 1'b0;
        in_ch.pts            = '0;
        in_ch.audio_clock_us = '0;
        out_ch.ready         = 1'b0;
        stall_left           = 0;
        tx_gaps              = 1'b1;
        rx_stalls            = 1'b1;
        cur_pts              = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: one microsecond per tick, 40 ms default.
        send_frame(1'b0, '0, '0);
        send_offset(1'b1, 48'sd20_000_000, 5000);
        send_offset(1'b1, 48'sd20_040_000, -5000);
        send_offset(1'b1, 48'sd20_080_000, 3000);
        send_offset(1'b1, 48'sd20_120_000, -3000);
        send_offset(1'b1, 48'sd20_160_000, 3001);
        send_offset(1'b1, 48'sd20_200_000, -3001);
        send_offset(1'b1, 48'sd20_240_000, 499999);
        send_offset(1'b1, 48'sd20_280_000, 500000);
        send_offset(1'b1, 48'sd20_320_000, -499999);
        send_offset(1'b1, 48'sd20_360_000, -500000);
        send_offset(1'b1, 48'sd20_400_000, 9999999);
        send_offset(1'b1, 48'sd20_440_000, 10000000);
        send_offset(1'b1, 48'sd20_480_000, -10000000);
        send_offset(1'b0, 48'sh1234_5678_9ABC, 7000);
        send_offset(1'b1, -48'sd5, -7000);
        send_offset(1'b1, 48'sh8000_0000_0000, 2000);
        send_offset(1'b1, '0, -4000);
        send_frame(1'b1, 48'sh7FFF_FFFF_FFFF, '1);
        send_frame(1'b1, 48'sh7FFF_FFFF_FFFF, '0);
        send_frame(1'b0, '0, '1);
        send_frame(1'b1, 48'sd1, '0);
        run_frames(190);

        wait_idle();
        write_config(32'd728178, 20'd33367);
        run_frames(110);

        wait_idle();
        write_config('0, '0);
        run_frames(60);

        wait_idle();
        write_config('1, 20'd1000000);
        run_frames(70);

        // One tick is far below a microsecond, so small timestamps scale to zero.
        wait_idle();
        write_config(32'd1, DEF_W'($urandom_range(0, 1000000)));
        send_offset(1'b1, 48'sd65535, 4000);
        send_offset(1'b1, 48'sd65536, -4000);
        send_offset(1'b1, 48'sd196608, 0);
        run_frames(60);

        wait_idle();
        write_config($urandom, DEF_W'($urandom_range(0, 1000000)));
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_frames(90);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_frames(100);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Checked %0d result words against %0d frame words under six tick/default",
                 sb.checked, sb.noted);
        $display("settings, covering near, far and lost offsets and timestamp edge cases.");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ av_sync_frame_delay.f @@
rtl/avs_pkg.sv
rtl/avs_if.sv
rtl/avs_scale.sv
rtl/avs_clock.sv
rtl/avs_delay.sv
rtl/av_sync_frame_delay.sv
sim/testbench.sv
